// ----- design/msfd_pkg.sv -----
// msfd_pkg: shared types, constants and helpers for the multi-switch frame decoder
// used by msfd_parser, msfd_banks and multi_switch_frame_decoder
`default_nettype none

package msfd_pkg;

  localparam int GROUPS = 8;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam int POS_W = 10;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(1023);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_BASE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REALM       = 2'd3;

  localparam logic [7:0] SWITCH_BASE_RST = 8'd240;
  localparam logic [7:0] LED_BASE_RST    = 8'd248;
  localparam logic [7:0] SOURCE_RST      = 8'hEA;
  localparam logic [7:0] REALM_RST       = 8'hA1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    logic [63:0] switches_word;
    logic [63:0] leds_word;
    logic        has_data;
  } out_word_t;

  typedef struct packed {
    logic [7:0] switch_base_address;
    logic [7:0] led_base_address;
    logic [7:0] expected_source;
    logic [7:0] switch_realm;
  } cfg_t;

  // one bank write, already decoded to a group
  typedef struct packed {
    logic             sw_we;
    logic [GRP_W-1:0] sw_idx;
    logic             led_we;
    logic [GRP_W-1:0] led_idx;
    logic [7:0]       value;
  } wr_req_t;

  // bit i set when 2-bit pair i of the value is nonzero
  function automatic logic [7:0] squeeze_pairs(input logic [15:0] v);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[i] = |v[2*i +: 2];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/msfd_parser.sv -----
// msfd_parser: byte position tracking, header checks and command decoding
// depends on msfd_pkg; produces one bank write request per word
`default_nettype none

module msfd_parser import msfd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_word_t word_i,
  input  wire cfg_t     cfg_i,
  output wr_req_t       wr_req_o
);

  localparam logic [7:0] CMD_SET    = 8'h01;
  localparam logic [7:0] CMD_SET4   = 8'h07;
  localparam logic [7:0] CMD_SET64  = 8'h08;
  localparam logic [7:0] CMD_SET4M  = 8'h09;
  localparam logic [7:0] DEST_LOW   = 8'hC0;
  localparam logic [7:0] DEST_HIGH  = 8'hCF;

  logic [POS_W-1:0] pos_q, pos_d, pos;
  logic             dest_ok_q, dest_ok_d, src_ok_q, src_ok_d, realm_ok_q, realm_ok_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       aoc_q, aoc_d;
  logic [7:0]       entry_addr_q, entry_addr_d;
  logic [7:0]       held_q, held_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       done_q, done_d;

  logic             grp_we;
  logic [7:0]       grp_addr;
  logic             set64_we;
  logic [7:0]       value;
  logic [7:0]       b;
  logic [8:0]       sw_diff, led_diff;
  logic             sw_hit, led_hit;

  always_comb begin
    b          = word_i.data_byte;
    pos        = word_i.frame_start ? '0 : pos_q;
    dest_ok_d  = word_i.frame_start ? 1'b0 : dest_ok_q;
    src_ok_d   = word_i.frame_start ? 1'b0 : src_ok_q;
    realm_ok_d = word_i.frame_start ? 1'b0 : realm_ok_q;
    cmd_d      = word_i.frame_start ? 8'h00 : cmd_q;
    aoc_d        = aoc_q;
    entry_addr_d = entry_addr_q;
    held_d       = held_q;
    phase_d      = phase_q;
    done_d       = done_q;
    grp_we   = 1'b0;
    grp_addr = aoc_q;
    set64_we = 1'b0;
    value    = squeeze_pairs({held_q, b});

    if (pos == POS_W'(3)) begin
      dest_ok_d = (b >= DEST_LOW) && (b <= DEST_HIGH);
    end else if (pos == POS_W'(4)) begin
      src_ok_d = (b == cfg_i.expected_source);
    end else if (pos == POS_W'(5)) begin
      realm_ok_d = (b == cfg_i.switch_realm);
    end else if (pos == POS_W'(6)) begin
      cmd_d = b;
    end else if (pos == POS_W'(7)) begin
      aoc_d   = b;
      phase_d = 2'd0;
      done_d  = 8'd0;
    end else if (pos >= POS_W'(8) && dest_ok_q && src_ok_q && realm_ok_q) begin
      case (cmd_q)
        CMD_SET: begin
          if (pos == POS_W'(8)) begin
            grp_we = 1'b1;
            value  = b;
          end
        end
        CMD_SET4: begin
          if (pos == POS_W'(8)) begin
            held_d = b;
          end else if (pos == POS_W'(9)) begin
            grp_we = 1'b1;
          end
        end
        CMD_SET4M: begin
          if (done_q < aoc_q) begin
            if (phase_q == 2'd0) begin
              entry_addr_d = b;
              phase_d      = 2'd1;
            end else if (phase_q == 2'd1) begin
              held_d  = b;
              phase_d = 2'd2;
            end else begin
              grp_we   = 1'b1;
              grp_addr = entry_addr_q;
              done_d   = done_q + 8'd1;
              phase_d  = 2'd0;
            end
          end
        end
        CMD_SET64: begin
          if (pos == POS_W'(8)) begin
            entry_addr_d = b & 8'h07;
          end else if (pos == POS_W'(9)) begin
            held_d = b;
          end else if (pos == POS_W'(10)) begin
            set64_we = (aoc_q == cfg_i.switch_base_address) &&
                       (entry_addr_q < 8'(GROUPS));
          end
        end
        default: begin
        end
      endcase
    end

    pos_d = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;

    // switch range wins when an address falls in both
    sw_diff  = {1'b0, grp_addr} - {1'b0, cfg_i.switch_base_address};
    led_diff = {1'b0, grp_addr} - {1'b0, cfg_i.led_base_address};
    sw_hit   = !sw_diff[8] && (sw_diff[7:0] < 8'(GROUPS));
    led_hit  = !led_diff[8] && (led_diff[7:0] < 8'(GROUPS));

    wr_req_o.value   = value;
    wr_req_o.sw_we   = set64_we || (grp_we && sw_hit);
    wr_req_o.sw_idx  = set64_we ? entry_addr_q[GRP_W-1:0] : sw_diff[GRP_W-1:0];
    wr_req_o.led_we  = grp_we && !sw_hit && led_hit;
    wr_req_o.led_idx = led_diff[GRP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      dest_ok_q    <= 1'b0;
      src_ok_q     <= 1'b0;
      realm_ok_q   <= 1'b0;
      cmd_q        <= '0;
      aoc_q        <= '0;
      entry_addr_q <= '0;
      held_q       <= '0;
      phase_q      <= '0;
      done_q       <= '0;
    end else if (step_i) begin
      pos_q        <= pos_d;
      dest_ok_q    <= dest_ok_d;
      src_ok_q     <= src_ok_d;
      realm_ok_q   <= realm_ok_d;
      cmd_q        <= cmd_d;
      aoc_q        <= aoc_d;
      entry_addr_q <= entry_addr_d;
      held_q       <= held_d;
      phase_q      <= phase_d;
      done_q       <= done_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/msfd_banks.sv -----
// msfd_banks: switch and led group registers plus the data-seen flag
// depends on msfd_pkg; the registers double as the result payload
`default_nettype none

module msfd_banks import msfd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire wr_req_t wr_req_i,
  output out_word_t    word_o
);

  logic [7:0] sw_bank_q  [GROUPS];
  logic [7:0] led_bank_q [GROUPS];
  logic       seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) begin
        sw_bank_q[g]  <= '0;
        led_bank_q[g] <= '0;
      end
      seen_q <= 1'b0;
    end else if (step_i) begin
      if (wr_req_i.sw_we) begin
        sw_bank_q[wr_req_i.sw_idx] <= wr_req_i.value;
      end
      if (wr_req_i.led_we) begin
        led_bank_q[wr_req_i.led_idx] <= wr_req_i.value;
      end
      if (wr_req_i.sw_we || wr_req_i.led_we) begin
        seen_q <= 1'b1;
      end
    end
  end

  // groups past GROUPS read as zero
  always_comb begin
    word_o = '0;
    for (int g = 0; g < GROUPS; g++) begin
      word_o.switches_word[8*g +: 8] = sw_bank_q[g];
      word_o.leds_word[8*g +: 8]     = led_bank_q[g];
    end
    word_o.has_data = seen_q;
  end

endmodule

`default_nettype wire

// ----- design/multi_switch_frame_decoder.sv -----
// multi_switch_frame_decoder: top level with input register, handshake and config registers
// depends on msfd_pkg, msfd_parser and msfd_banks
`default_nettype none

// Decodes switch control frames arriving one byte per word and keeps eight
// switch groups, eight led groups and a data-seen flag. Every accepted input
// word yields exactly one output word carrying both banks and the flag as they
// stand after that byte. A word is held in the input register and then passes
// through the byte decoder into the bank registers; a new word is taken every
// cycle while the output side keeps up, the rate being set by the single
// register-to-register pass through the byte decoder. Configuration registers
// are written through cfg_we_i/cfg_index_i/
// cfg_data_i and must only change while no word is in flight.
module multi_switch_frame_decoder import msfd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire in_word_t             in_word_i,
  // result words
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output out_word_t                 out_word_o,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  cfg_t     cfg_q;
  in_word_t s1_word_q;
  logic     s1_valid_q;
  logic     out_valid_q;
  logic     out_ready;
  logic     step;
  logic     in_take;
  wr_req_t  wr_req;

  // output register is free when empty or being taken
  assign out_ready  = !out_valid_q || !out_stall_i;
  // move the staged word through the decoder into the banks
  assign step       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.switch_base_address <= SWITCH_BASE_RST;
      cfg_q.led_base_address    <= LED_BASE_RST;
      cfg_q.expected_source     <= SOURCE_RST;
      cfg_q.switch_realm        <= REALM_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SWITCH_BASE: cfg_q.switch_base_address <= cfg_data_i;
        CFG_LED_BASE:    cfg_q.led_base_address    <= cfg_data_i;
        CFG_SOURCE:      cfg_q.expected_source     <= cfg_data_i;
        CFG_REALM:       cfg_q.switch_realm        <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input stage and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_word_q <= in_word_i;
    end
  end

  msfd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (s1_word_q),
    .cfg_i    (cfg_q),
    .wr_req_o (wr_req)
  );

  // the banks only change on a step, so they hold while the result is stalled
  msfd_banks u_banks (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .wr_req_i (wr_req),
    .word_o   (out_word_o)
  );

  // banks never change without a word moving into the output
  a_banks_move_on_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(out_word_o) |-> $past(step))
    else $error("bank contents changed without a step");

  // data-seen flag is sticky
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(out_word_o.has_data))
    else $error("has_data dropped");

  // flag rises only from an applied write
  a_seen_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_word_o.has_data) |-> $past(step && (wr_req.sw_we || wr_req.led_we)))
    else $error("has_data rose without a write");

  // stalling the input only when a word is staged
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty stage");

  // a step always produces a result word
  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("step lost a result");

endmodule

`default_nettype wire

// ----- verif/switch_frame_check.sv -----
// frame_tb_pkg and switch_frame_check: frame codes shared by the bench, and a
// scoreboard that mirrors the decoder and compares every result word
// depends on msfd_pkg for the word, register and reset definitions
`timescale 1ns / 100ps

package frame_tb_pkg;

  // command codes carried in the command byte
  localparam logic [7:0] CMD_SET   = 8'h01;
  localparam logic [7:0] CMD_SET4  = 8'h07;
  localparam logic [7:0] CMD_SET64 = 8'h08;
  localparam logic [7:0] CMD_SET4M = 8'h09;

  // accepted destination range
  localparam logic [7:0] DEST_LOW  = 8'hC0;
  localparam logic [7:0] DEST_HIGH = 8'hCF;

  // byte positions inside a frame
  localparam int POS_DEST   = 3;
  localparam int POS_SOURCE = 4;
  localparam int POS_REALM  = 5;
  localparam int POS_CMD    = 6;
  localparam int POS_ARG    = 7;
  localparam int POS_DATA   = 8;

  localparam int FRAME_LATENCY = 2;

endpackage

module switch_frame_check
  import msfd_pkg::*;
  import frame_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_word_t             in_word_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_word_t            out_word_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);

  typedef enum logic [1:0] {TAKE_ADDR, TAKE_HIGH, TAKE_LOW} triple_step_t;

  cfg_t         cfg_q;
  logic [9:0]   pos_q;
  logic         dest_ok, src_ok, realm_ok;
  logic [7:0]   cmd_q, arg_q, entry_q, held_q, done_q;
  triple_step_t step_q;
  logic [7:0]   sw_bank [GROUPS];
  logic [7:0]   led_bank [GROUPS];
  logic         seen_q;

  out_word_t    words_due [$];
  int           fails, checked;

  // one result bit per 2-bit pair, set when the pair is not zero
  function automatic logic [7:0] fold_pairs(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] v;
    logic [7:0]  r;
    v = {hi, lo};
    for (int i = 0; i < 8; i++) r[i] = v[2*i] | v[2*i+1];
    return r;
  endfunction

  // switch range wins over led range, no wrap past 255
  task automatic store_group(input logic [7:0] addr, input logic [7:0] value);
    int a, sb, lb;
    a  = addr;
    sb = cfg_q.switch_base_address;
    lb = cfg_q.led_base_address;
    if (a >= sb && a - sb < GROUPS) begin
      sw_bank[a - sb] = value;
      seen_q = 1'b1;
    end else if (a >= lb && a - lb < GROUPS) begin
      led_bank[a - lb] = value;
      seen_q = 1'b1;
    end
  endtask

  task automatic run_command(input logic [9:0] at, input logic [7:0] b);
    case (cmd_q)
      CMD_SET: begin
        if (at == POS_DATA) store_group(arg_q, b);
      end
      CMD_SET4: begin
        if (at == POS_DATA) held_q = b;
        else if (at == POS_DATA + 1) store_group(arg_q, fold_pairs(held_q, b));
      end
      CMD_SET4M: begin
        if (done_q < arg_q) begin
          case (step_q)
            TAKE_ADDR: begin
              entry_q = b;
              step_q  = TAKE_HIGH;
            end
            TAKE_HIGH: begin
              held_q = b;
              step_q = TAKE_LOW;
            end
            default: begin
              store_group(entry_q, fold_pairs(held_q, b));
              done_q = done_q + 8'd1;
              step_q = TAKE_ADDR;
            end
          endcase
        end
      end
      CMD_SET64: begin
        if (at == POS_DATA) entry_q = b & 8'd7;
        else if (at == POS_DATA + 1) held_q = b;
        else if (at == POS_DATA + 2) begin
          if (arg_q == cfg_q.switch_base_address && entry_q < GROUPS) begin
            sw_bank[entry_q] = fold_pairs(held_q, b);
            seen_q = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // advance the mirrored decoder by one byte and return the banks after it
  task automatic decode_byte(input in_word_t w, output out_word_t r);
    logic [7:0] b;
    logic [9:0] at;
    b = w.data_byte;
    if (w.frame_start) begin
      pos_q    = '0;
      dest_ok  = 1'b0;
      src_ok   = 1'b0;
      realm_ok = 1'b0;
      cmd_q    = '0;
    end
    at = pos_q;
    if (at == POS_DEST) begin
      dest_ok = (b >= DEST_LOW && b <= DEST_HIGH);
    end else if (at == POS_SOURCE) begin
      src_ok = (b == cfg_q.expected_source);
    end else if (at == POS_REALM) begin
      realm_ok = (b == cfg_q.switch_realm);
    end else if (at == POS_CMD) begin
      cmd_q = b;
    end else if (at == POS_ARG) begin
      arg_q  = b;
      step_q = TAKE_ADDR;
      done_q = '0;
    end else if (at >= POS_DATA && dest_ok && src_ok && realm_ok) begin
      run_command(at, b);
    end
    if (at != POS_MAX) pos_q = at + 10'd1;
    for (int g = 0; g < 8; g++) begin
      r.switches_word[8*g +: 8] = (g < GROUPS) ? sw_bank[g] : 8'h00;
      r.leds_word[8*g +: 8]     = (g < GROUPS) ? led_bank[g] : 8'h00;
    end
    r.has_data = seen_q;
  endtask

  task automatic clear_model();
    cfg_q.switch_base_address = SWITCH_BASE_RST;
    cfg_q.led_base_address    = LED_BASE_RST;
    cfg_q.expected_source     = SOURCE_RST;
    cfg_q.switch_realm        = REALM_RST;
    pos_q    = '0;
    dest_ok  = 1'b0;
    src_ok   = 1'b0;
    realm_ok = 1'b0;
    cmd_q    = '0;
    arg_q    = '0;
    entry_q  = '0;
    held_q   = '0;
    done_q   = '0;
    step_q   = TAKE_ADDR;
    seen_q   = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      sw_bank[g]  = '0;
      led_bank[g] = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want, made;
    if (!rst_ni) begin
      clear_model();
      words_due.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SWITCH_BASE: cfg_q.switch_base_address = cfg_data_i;
          CFG_LED_BASE:    cfg_q.led_base_address    = cfg_data_i;
          CFG_SOURCE:      cfg_q.expected_source     = cfg_data_i;
          CFG_REALM:       cfg_q.switch_realm        = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (words_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected result word, expected none, got %h", $time, out_word_i);
        end else begin
          want = words_due.pop_front();
          checked++;
          if (out_word_i.switches_word !== want.switches_word) begin
            fails++;
            $display("%0t: switches_word expected %h got %h", $time,
                     want.switches_word, out_word_i.switches_word);
          end
          if (out_word_i.leds_word !== want.leds_word) begin
            fails++;
            $display("%0t: leds_word expected %h got %h", $time,
                     want.leds_word, out_word_i.leds_word);
          end
          if (out_word_i.has_data !== want.has_data) begin
            fails++;
            $display("%0t: has_data expected %b got %b", $time,
                     want.has_data, out_word_i.has_data);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_word_i, made);
        words_due.push_back(made);
      end
    end
    fail_count_o <= fails;
    pending_o    <= words_due.size();
    checked_o    <= checked;
  end

endmodule

// ----- verif/testbench.sv -----
// testbench: drives control frames and register settings into the frame decoder
// depends on msfd_pkg, frame_tb_pkg and switch_frame_check, which does the checking
`timescale 1ns / 100ps

module testbench;
  import msfd_pkg::*;
  import frame_tb_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 150000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_WORDS  = 90;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // block inputs, all known from time zero
  logic                 in_valid  = 1'b0;
  in_word_t             in_word   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data  = '0;

  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  // scoreboard results
  int fail_count, pending, checked;

  // knobs shared between the sender and the receiver
  logic gaps_on      = 1'b1;
  logic stalls_on    = 1'b1;
  int   hold_tickets = 0;

  // bookkeeping for the sender
  cfg_t       cfg_now;
  logic [7:0] frame_q [$];
  int         words_sent  = 0;
  int         frames_sent = 0;
  int         cycle_count = 0;

  multi_switch_frame_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  switch_frame_check frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due", $time, cycle_count,
               pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off each time the sender asks
  // for one; the hold is counted here so the sender keeps offering words
  int hold_served = 0;
  int hold_left   = 0;

  always @(posedge clk) begin
    if (hold_served != hold_tickets) begin
      hold_served = hold_tickets;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stalls_on && ($urandom_range(0, 99) < 31);
    end
  end

  // offer one word, with a random gap in front when gaps are on; returns at
  // the edge that took it, leaving valid high so back-to-back words need no
  // second assignment in the same step
  task automatic send_word(input logic [7:0] b, input logic first);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_word.data_byte     <= b;
    in_word.frame_start   <= first;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // frame_q goes out byte by byte; without the start flag the bytes simply
  // continue from wherever the decoder's position stands
  task automatic send_frame(input logic with_start);
    foreach (frame_q[k]) send_word(frame_q[k], with_start && k == 0);
    frames_sent++;
  endtask

  // stop offering and wait until every result word has come back, then let
  // the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (FRAME_LATENCY + 2) @(posedge clk);
  endtask

  // write all four registers on consecutive edges; only called when idle
  task automatic set_config(input logic [7:0] sw_base, input logic [7:0] led_base,
                            input logic [7:0] source, input logic [7:0] realm);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SWITCH_BASE;
    cfg_data  <= sw_base;
    @(posedge clk);
    cfg_index <= CFG_LED_BASE;
    cfg_data  <= led_base;
    @(posedge clk);
    cfg_index <= CFG_SOURCE;
    cfg_data  <= source;
    @(posedge clk);
    cfg_index <= CFG_REALM;
    cfg_data  <= realm;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now.switch_base_address = sw_base;
    cfg_now.led_base_address    = led_base;
    cfg_now.expected_source     = source;
    cfg_now.switch_realm        = realm;
  endtask

  // mostly addresses inside one of the two ranges (an 8-bit wrap past 255 puts
  // some outside, as a range stops at 255), some just outside, some anywhere
  function automatic logic [7:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return cfg_now.switch_base_address + 8'($urandom_range(0, 7));
      4, 5, 6, 7: return cfg_now.led_base_address + 8'($urandom_range(0, 7));
      8:          return $urandom_range(0, 1) ? cfg_now.switch_base_address - 8'd1
                                              : cfg_now.led_base_address + 8'd8;
      default:    return 8'($urandom);
    endcase
  endfunction

  // one frame: most are well formed with random content, the rest carry a
  // bad destination, source or realm, an unknown command, are cut short, or
  // come without a start flag
  task automatic random_frame();
    int         roll, cut;
    logic [7:0] dest, src, realm, cmd_code, arg;
    roll     = $urandom_range(0, 99);
    dest     = 8'($urandom_range(DEST_LOW, DEST_HIGH));
    src      = cfg_now.expected_source;
    realm    = cfg_now.switch_realm;
    case ($urandom_range(0, 3))
      0:       cmd_code = CMD_SET;
      1:       cmd_code = CMD_SET4;
      2:       cmd_code = CMD_SET4M;
      default: cmd_code = CMD_SET64;
    endcase
    arg = pick_address();
    if (roll < 5) dest = 8'($urandom);
    else if (roll < 9) src = src ^ (8'd1 << $urandom_range(0, 7));
    else if (roll < 13) realm = realm ^ (8'd1 << $urandom_range(0, 7));
    else if (roll < 17) cmd_code = 8'($urandom);
    // multi-entry counts stay small, now and then a bit larger
    if (cmd_code == CMD_SET4M)
      arg = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 12)) : 8'($urandom_range(0, 4));
    else if (cmd_code == CMD_SET64 && $urandom_range(0, 3) != 0)
      arg = cfg_now.switch_base_address;
    frame_q = {8'($urandom), 8'($urandom), 8'($urandom), dest, src, realm, cmd_code, arg};
    case (cmd_code)
      CMD_SET:   frame_q.push_back(8'($urandom));
      CMD_SET4:  repeat (2) frame_q.push_back(8'($urandom));
      CMD_SET64: repeat (3) frame_q.push_back(8'($urandom));
      CMD_SET4M: begin
        for (int i = 0; i < arg; i++) begin
          frame_q.push_back(pick_address());
          repeat (2) frame_q.push_back(8'($urandom));
        end
      end
      default:   repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
    endcase
    // trailing bytes past the command are ignored
    repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
    if (roll >= 17 && roll < 22) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    send_frame(!(roll >= 22 && roll < 25));
  endtask

  task automatic random_phase();
    int target;
    target = words_sent + PHASE_WORDS;
    while (words_sent < target) random_frame();
  endtask

  // multi-entry frame with the largest count, then filler out past the
  // position limit; the tail would read as a valid set frame if the position
  // wrapped instead of saturating
  task automatic long_frame();
    frame_q = {8'($urandom), 8'($urandom), 8'($urandom), DEST_LOW, cfg_now.expected_source,
               cfg_now.switch_realm, CMD_SET4M, 8'd255};
    repeat (255) begin
      frame_q.push_back(pick_address());
      repeat (2) frame_q.push_back(8'($urandom));
    end
    while (frame_q.size() < 1024 + POS_DEST) frame_q.push_back(8'($urandom));
    frame_q.push_back(DEST_HIGH);
    frame_q.push_back(cfg_now.expected_source);
    frame_q.push_back(cfg_now.switch_realm);
    frame_q.push_back(CMD_SET);
    frame_q.push_back(cfg_now.switch_base_address);
    frame_q.push_back(8'h5A);
    repeat (4) frame_q.push_back(8'($urandom));
    send_frame(1'b1);
  endtask

  initial begin
    cfg_now.switch_base_address = SWITCH_BASE_RST;
    cfg_now.led_base_address    = LED_BASE_RST;
    cfg_now.expected_source     = SOURCE_RST;
    cfg_now.switch_realm        = REALM_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a set frame right after reset with no start flag, so its
    // position counts from zero; it fills the first switch group
    frame_q = {8'h00, 8'hFF, 8'h00, DEST_LOW, SOURCE_RST, REALM_RST, CMD_SET,
               SWITCH_BASE_RST, 8'hFF};
    send_frame(1'b0);
    // top destination, last led group, value with every pair nonzero
    frame_q = {8'hFF, 8'h00, 8'hFF, DEST_HIGH, SOURCE_RST, REALM_RST, CMD_SET4,
               LED_BASE_RST + 8'd7, 8'hFF, 8'h55};
    send_frame(1'b1);
    // 64-switch write, group byte with high bits set (masked to group 7)
    frame_q = {8'h00, 8'h00, 8'h00, DEST_LOW, SOURCE_RST, REALM_RST, CMD_SET64,
               SWITCH_BASE_RST, 8'hFF, 8'h30, 8'h0C};
    send_frame(1'b1);

    // reset register values, with one long receiver hold-off while the
    // sender keeps going, so the decoder fills up and stalls its input
    hold_tickets <= hold_tickets + 1;
    random_phase();
    drain();

    // switch and led ranges overlap: the switch range has to win
    set_config(8'h10, 8'h14, 8'h5C, 8'h3E);
    random_phase();
    drain();

    // extreme register values and a stretch with no gaps or stalls at all;
    // the switch range is cut short at 255 here
    gaps_on   <= 1'b0;
    stalls_on <= 1'b0;
    set_config(8'hFC, 8'h00, 8'h00, 8'hFF);
    random_phase();
    long_frame();
    drain();
    gaps_on   <= 1'b1;
    stalls_on <= 1'b1;

    // the other extremes: led range is a single address
    set_config(8'h00, 8'hFF, 8'hFF, 8'h00);
    random_phase();
    drain();

    // random registers, and a second hold-off
    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    hold_tickets <= hold_tickets + 1;
    random_phase();
    drain();

    $display("covered %0d words in %0d frames under five register settings,", words_sent,
             frames_sent);
    $display("including a frame past the position limit; %0d result words compared", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
